// ===== sv/pecp_pkg.sv =====
// Package for the ellipse column point generator: widths, register codes,
// pipeline stage types and the per-step square root and division helpers.
// No dependencies.
package pecp_pkg;

    localparam int COORD_BITS  = 10;
    localparam int PT_BITS     = 12;
    localparam int CFG_IDX_BITS = 2;

    localparam int SQ_IN_BITS  = 4 * COORD_BITS;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int SQ_REM_BITS = 2 * COORD_BITS + 2;
    // two root bits resolved per square root stage
    localparam int SQ_STAGES   = COORD_BITS;
    // one quotient bit per division stage
    localparam int DIV_STAGES  = COORD_BITS;
    localparam int EXT_BITS    = PT_BITS + COORD_BITS;

    localparam logic [COORD_BITS-1:0] CENTER_X_RST = COORD_BITS'(300);
    localparam logic [COORD_BITS-1:0] CENTER_Y_RST = COORD_BITS'(300);
    localparam logic [COORD_BITS-1:0] AXIS_X_RST   = COORD_BITS'(100);
    localparam logic [COORD_BITS-1:0] AXIS_Y_RST   = COORD_BITS'(50);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CENTER_X    = 2'd0,
        REG_CENTER_Y    = 2'd1,
        REG_SEMI_AXIS_X = 2'd2,
        REG_SEMI_AXIS_Y = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                   vld;
        logic [COORD_BITS-1:0]  x;
        logic [SQ_REM_BITS-1:0] rem;
        logic [SQ_BITS-1:0]     root;
        logic [SQ_IN_BITS-1:0]  src;
    } t_sq_stage;

    typedef struct packed {
        logic                  vld;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] rem;
        logic [COORD_BITS-1:0] src;
        logic [COORD_BITS-1:0] q;
    } t_dv_stage;

    // One digit of the restoring square root: bring down two radicand bits.
    function automatic t_sq_stage sq_step(t_sq_stage st);
        t_sq_stage              nx;
        logic [SQ_REM_BITS-1:0] rem_sh;
        logic [SQ_REM_BITS-1:0] trial;
        nx     = st;
        rem_sh = {st.rem[SQ_REM_BITS-3:0], st.src[SQ_IN_BITS-1 -: 2]};
        trial  = {st.root, 2'b01};
        if (rem_sh >= trial) begin
            nx.rem  = rem_sh - trial;
            nx.root = {st.root[SQ_BITS-2:0], 1'b1};
        end else begin
            nx.rem  = rem_sh;
            nx.root = {st.root[SQ_BITS-2:0], 1'b0};
        end
        nx.src = {st.src[SQ_IN_BITS-3:0], 2'b00};
        return nx;
    endfunction

    // One quotient bit of restoring division; remainder stays below the divisor.
    function automatic t_dv_stage dv_step(t_dv_stage st, logic [COORD_BITS-1:0] dvsr);
        t_dv_stage           nx;
        logic [COORD_BITS:0] rem2;
        logic [COORD_BITS:0] diff;
        nx   = st;
        rem2 = {st.rem, st.src[COORD_BITS-1]};
        diff = rem2 - {1'b0, dvsr};
        if (rem2 >= {1'b0, dvsr}) begin
            nx.rem = diff[COORD_BITS-1:0];
            nx.q   = {st.q[COORD_BITS-2:0], 1'b1};
        end else begin
            nx.rem = rem2[COORD_BITS-1:0];
            nx.q   = {st.q[COORD_BITS-2:0], 1'b0};
        end
        nx.src = {st.src[COORD_BITS-2:0], 1'b0};
        return nx;
    endfunction

endpackage

// ===== sv/polynomial_ellipse_column_points.sv =====
// Ellipse column points: y = floor(sqrt(b*b*(a*a-x*x))/a), then four mirrored points.
// A request passes the input, square, difference and product stages, then the square
// root and division stages to the point emitter; the four points follow on consecutive
// cycles. The emitter takes a new column only with the last point of the one before;
// the pipeline holds while a finished column waits at its end. The receiver cannot
// stall. Synchronous active-low reset restores the register defaults and clears all valid bits.
module polynomial_ellipse_column_points
    import pecp_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [COORD_BITS-1:0]       i_cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [COORD_BITS-1:0]       i_column_offset,
    output logic                        o_valid,
    output logic signed [PT_BITS-1:0]   o_point_x,
    output logic signed [PT_BITS-1:0]   o_point_y,
    output logic [1:0]                  o_quadrant,
    output logic                        o_last_point
);

    logic [COORD_BITS-1:0] r_h, r_k, r_a, r_b;

    logic                  r_p0_vld;
    logic [COORD_BITS-1:0] r_p0_x;
    logic                  r_p1_vld;
    logic [COORD_BITS-1:0] r_p1_x;
    logic [SQ_BITS-1:0]    r_p1_aa, r_p1_xx, r_p1_bb;
    logic                  r_p2_vld;
    logic [COORD_BITS-1:0] r_p2_x;
    logic [SQ_BITS-1:0]    r_p2_diff, r_p2_bb;
    logic                  r_p3_vld;
    logic [COORD_BITS-1:0] r_p3_x;
    logic [SQ_IN_BITS-1:0] r_p3_prod;

    t_sq_stage r_sq [SQ_STAGES];
    t_sq_stage n_sq [SQ_STAGES];
    t_dv_stage r_dv [DIV_STAGES];
    t_dv_stage n_dv [DIV_STAGES];

    logic                  r_em_vld;
    logic [1:0]            r_em_cnt;
    logic [COORD_BITS-1:0] r_em_x, r_em_y;

    logic                  stall;
    logic                  em_load;
    logic [COORD_BITS-1:0] n_p0_x;
    logic [COORD_BITS-1:0] n_em_y;
    t_sq_stage             sq_init;
    t_dv_stage             dv_init;
    logic [EXT_BITS-1:0]   w_px, w_py;

    // hold the whole pipeline while the emitter still owes points and a column waits
    assign stall   = r_dv[DIV_STAGES-1].vld && r_em_vld && (r_em_cnt != 2'd3);
    assign busy    = stall;
    assign em_load = r_dv[DIV_STAGES-1].vld && !stall;

    // clamp the offset to the semi-axis; a flat ellipse forces x to zero
    always_comb begin
        if (r_a == '0) begin
            n_p0_x = '0;
        end else if (i_column_offset > r_a) begin
            n_p0_x = r_a;
        end else begin
            n_p0_x = i_column_offset;
        end
    end

    always_comb begin
        sq_init      = '0;
        sq_init.vld  = r_p3_vld;
        sq_init.x    = r_p3_x;
        sq_init.src  = r_p3_prod;
        n_sq[0]      = sq_step(sq_step(sq_init));
        for (int s = 1; s < SQ_STAGES; s++) begin
            n_sq[s] = sq_step(sq_step(r_sq[s-1]));
        end
    end

    always_comb begin
        dv_init      = '0;
        dv_init.vld  = r_sq[SQ_STAGES-1].vld;
        dv_init.x    = r_sq[SQ_STAGES-1].x;
        dv_init.rem  = r_sq[SQ_STAGES-1].root[SQ_BITS-1:COORD_BITS];
        dv_init.src  = r_sq[SQ_STAGES-1].root[COORD_BITS-1:0];
        n_dv[0]      = dv_step(dv_init, r_a);
        for (int s = 1; s < DIV_STAGES; s++) begin
            n_dv[s] = dv_step(r_dv[s-1], r_a);
        end
    end

    assign n_em_y = (r_a == '0) ? r_b : r_dv[DIV_STAGES-1].q;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h      <= CENTER_X_RST;
            r_k      <= CENTER_Y_RST;
            r_a      <= AXIS_X_RST;
            r_b      <= AXIS_Y_RST;
            r_p0_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            for (int s = 0; s < SQ_STAGES; s++) r_sq[s].vld <= 1'b0;
            for (int s = 0; s < DIV_STAGES; s++) r_dv[s].vld <= 1'b0;
            r_em_vld <= 1'b0;
            r_em_cnt <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_CENTER_X:    r_h <= i_cfg_data;
                    REG_CENTER_Y:    r_k <= i_cfg_data;
                    REG_SEMI_AXIS_X: r_a <= i_cfg_data;
                    REG_SEMI_AXIS_Y: r_b <= i_cfg_data;
                endcase
            end
            if (!stall) begin
                r_p0_vld <= start;
                r_p1_vld <= r_p0_vld;
                r_p2_vld <= r_p1_vld;
                r_p3_vld <= r_p2_vld;
                r_sq     <= n_sq;
                r_dv     <= n_dv;
            end
            if (em_load) begin
                r_em_vld <= 1'b1;
                r_em_cnt <= 2'd0;
            end else if (r_em_vld) begin
                if (r_em_cnt == 2'd3) begin
                    r_em_vld <= 1'b0;
                end
                r_em_cnt <= r_em_cnt + 2'd1;
            end
        end
    end

    // datapath of the front stages and the emitter
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_p0_x    <= n_p0_x;
            r_p1_x    <= r_p0_x;
            r_p1_aa   <= r_a * r_a;
            r_p1_xx   <= r_p0_x * r_p0_x;
            r_p1_bb   <= r_b * r_b;
            r_p2_x    <= r_p1_x;
            r_p2_diff <= r_p1_aa - r_p1_xx;
            r_p2_bb   <= r_p1_bb;
            r_p3_x    <= r_p2_x;
            r_p3_prod <= r_p2_bb * r_p2_diff;
        end
        if (em_load) begin
            r_em_x <= r_dv[DIV_STAGES-1].x;
            r_em_y <= n_em_y;
        end
    end

    // quadrant bit 1 mirrors x, bit 0 mirrors y; coordinates wrap to the point width
    assign w_px = r_em_cnt[1] ? ({{PT_BITS{1'b0}}, r_h} - {{PT_BITS{1'b0}}, r_em_x})
                              : ({{PT_BITS{1'b0}}, r_h} + {{PT_BITS{1'b0}}, r_em_x});
    assign w_py = r_em_cnt[0] ? ({{PT_BITS{1'b0}}, r_k} - {{PT_BITS{1'b0}}, r_em_y})
                              : ({{PT_BITS{1'b0}}, r_k} + {{PT_BITS{1'b0}}, r_em_y});

    assign o_valid      = r_em_vld;
    assign o_point_x    = w_px[PT_BITS-1:0];
    assign o_point_y    = w_py[PT_BITS-1:0];
    assign o_quadrant   = r_em_cnt;
    assign o_last_point = r_em_vld && (r_em_cnt == 2'd3);

    a_busy_needs_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_valid)
        else $error("busy without points in flight");

    a_points_consecutive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_point |=> o_valid && (o_quadrant == $past(o_quadrant) + 2'd1))
        else $error("column points not consecutive");

    a_same_x_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_quadrant == 2'd0) |=> o_point_x == $past(o_point_x))
        else $error("x changed within a mirrored pair");

endmodule
